[rtl/goertzel_tone_detector_assert.svh]
// Assertion macros used by the checker of the Goertzel tone detector.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef GOERTZEL_TONE_DETECTOR_ASSERT_SVH
`define GOERTZEL_TONE_DETECTOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gtd_pkg.sv]
// Package of the Goertzel tone detector: widths, codes, command/status types
// and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gtd_pkg;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int STATE_W    = 48;
    localparam int BLEN_W     = 13;
    localparam int COEF_W     = 18;
    localparam int SCALE_W    = 26;
    localparam int MAG_W      = 17;
    localparam int PH_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 26;

    localparam int MAX_BLOCK_DEF = 4096;

    // shared multiplier: A split into two 25-bit halves
    localparam int MUL_A_W  = 50;
    localparam int MUL_B_W  = 27;
    localparam int MUL_H_W  = 25;
    localparam int MUL_PP_W = 53;
    localparam int MUL_P_W  = 77;

    // magnitude and square root
    localparam int MAG_MAX    = 131071;
    localparam int RS_W       = 53;
    localparam int SQ_W       = 36;
    localparam int SQRT_STEPS = 18;

    // CORDIC
    localparam int CORD_W     = 34;
    localparam int Z_W        = 28;
    localparam int CORD_STEPS = 24;
    localparam int IDX_W      = 5;
    localparam int PI_Q24     = 52707179;
    localparam int PHASE_LIM  = 25736;
    localparam int NORM_BIT   = 30;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLEN  = 2'd0,
        CFG_COS   = 2'd1,
        CFG_SIN   = 2'd2,
        CFG_SCALE = 2'd3
    } t_cfg_idx;

    // datapath multiply-and-apply operations
    typedef enum logic [2:0] {
        OP_REC = 3'd0,   // recurrence q0
        OP_RE  = 3'd1,   // real part
        OP_IM  = 3'd2,   // imaginary part
        OP_RS  = 3'd3,   // scaled real part
        OP_IS  = 3'd4,   // scaled imaginary part
        OP_RS2 = 3'd5,   // rs squared
        OP_IS2 = 3'd6    // is squared, added
    } t_op;

    typedef struct packed {
        logic             load_smp;
        logic             mul_lo;
        logic             mul_hi;
        logic             mul_add;
        logic             apply;
        t_op              op;
        logic             sqrt_step;
        logic             norm_shift;
        logic             cord_init;
        logic             cord_step;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic norm_fit;
        logic origin;
    } t_dp_sts;

    // arctangent of 2^-i in Q.24
    function automatic logic signed [Z_W-1:0] atan_q24(input logic [IDX_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:    v = Z_W'(13176795);
            5'd1:    v = Z_W'(7778716);
            5'd2:    v = Z_W'(4110061);
            5'd3:    v = Z_W'(2086331);
            5'd4:    v = Z_W'(1047214);
            5'd5:    v = Z_W'(524117);
            5'd6:    v = Z_W'(262123);
            5'd7:    v = Z_W'(131069);
            5'd8:    v = Z_W'(65536);
            default: v = Z_W'(1) << (5'd24 - i);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/gtd_if.sv]
// Handshake channels of the Goertzel tone detector: samples, results, config.
// Depends on gtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gtd_sample_if import gtd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface gtd_result_if import gtd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [MAG_W-1:0]        magnitude;
    logic signed [PH_W-1:0]  phase;
    modport source (output valid, output magnitude, output phase, input ready);
    modport sink   (input valid, input magnitude, input phase, output ready);
endinterface

interface gtd_cfg_if import gtd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/goertzel_tone_detector.sv]
// Goertzel single-bin tone detector, top level: config registers, controller
// and datapath. Depends on gtd_pkg, gtd_if, gtd_ctrl and gtd_dp.
//
// Use:
//   i_smp  - signed sample beats in (valid/ready).
//   o_res  - one beat per completed block: magnitude and phase (Q3.13).
//   i_cfg  - register writes: 0 block_length, 1 cos_coef, 2 sin_coef,
//            3 scale_recip; always ready, write only while idle.
// Samples: each sample goes through one shared 26x27 multiplier in two
// halves plus an accumulate and an update before the next one is taken.
// After the last sample of a block come the last update, six multiplies,
// 18 square-root steps, a normalise check with up to 19 halving shifts,
// 24 CORDIC steps and the load of the output register that makes the result
// valid, during which no sample is taken.
// A finished result sits in an output register; while the receiver stalls,
// the next block's samples are still accepted, and a following result waits
// until that register is taken.
// Reset (synchronous, active low) restores register defaults and clears the
// recurrence state, sample count and any pending result.
`timescale 1ns / 1ps
`default_nettype none

module goertzel_tone_detector import gtd_pkg::*; #(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    gtd_sample_if.sink    i_smp,
    gtd_result_if.source  o_res,
    gtd_cfg_if.sink       i_cfg
);

    logic [BLEN_W-1:0]        r_blen;
    logic signed [COEF_W-1:0] r_cos, r_sin;
    logic [SCALE_W-1:0]       r_scale;
    t_dp_cmd                  w_cmd;
    t_dp_sts                  w_sts;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blen  <= BLEN_W'(256);
            r_cos   <= COEF_W'(65536);
            r_sin   <= '0;
            r_scale <= SCALE_W'(131072);
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_BLEN:  r_blen  <= i_cfg.data[BLEN_W-1:0];
                CFG_COS:   r_cos   <= i_cfg.data[COEF_W-1:0];
                CFG_SIN:   r_sin   <= i_cfg.data[COEF_W-1:0];
                CFG_SCALE: r_scale <= i_cfg.data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    gtd_ctrl #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_block_length (r_blen),
        .i_in_valid     (i_smp.valid),
        .o_in_ready     (i_smp.ready),
        .o_out_valid    (o_res.valid),
        .i_out_ready    (o_res.ready),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd)
    );

    gtd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_sample    (i_smp.sample),
        .i_cos       (r_cos),
        .i_sin       (r_sin),
        .i_scale     (r_scale),
        .o_sts       (w_sts),
        .o_magnitude (o_res.magnitude),
        .o_phase     (o_res.phase)
    );

endmodule

`default_nettype wire

[rtl/gtd_dp.sv]
// Datapath: recurrence state, shared split multiplier, square root,
// phase normalise and CORDIC, result payload register. Depends on gtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gtd_dp import gtd_pkg::*; (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  wire signed [SAMPLE_W-1:0]  i_sample,
    input  wire signed [COEF_W-1:0]    i_cos,
    input  wire signed [COEF_W-1:0]    i_sin,
    input  wire [SCALE_W-1:0]          i_scale,
    output t_dp_sts                    o_sts,
    output logic [MAG_W-1:0]           o_magnitude,
    output logic signed [PH_W-1:0]     o_phase
);

    localparam logic signed [MUL_P_W-1:0] HALF16 = MUL_P_W'(1) <<< 15;
    localparam logic signed [MUL_P_W-1:0] HALF24 = MUL_P_W'(1) <<< 23;
    localparam logic signed [MUL_P_W-1:0] ST_HI  = (MUL_P_W'(1) <<< (STATE_W-1)) - 1;
    localparam logic signed [MUL_P_W-1:0] ST_LO  = -ST_HI - 1;
    localparam logic signed [RS_W-1:0]    RS_HI  = RS_W'(MAG_MAX);
    localparam logic signed [RS_W-1:0]    RS_LO  = -RS_W'(MAG_MAX);
    localparam logic signed [Z_W-1:0]     PI_Z   = Z_W'(PI_Q24);
    localparam logic signed [Z_W-1:0]     ZRND   = Z_W'(1024);
    localparam logic signed [Z_W-12:0]    PLIM   = (Z_W-11)'(PHASE_LIM);

    logic signed [SAMPLE_W-1:0] r_smp;
    logic signed [STATE_W-1:0]  r_q1, r_q2;
    logic signed [MUL_PP_W-1:0] r_prod;
    logic signed [MUL_P_W-1:0]  r_acc;
    logic signed [MUL_A_W-1:0]  r_re, r_im;
    logic signed [RS_W-1:0]     r_rs, r_is;
    logic [SQ_W-1:0]            r_sq, r_root;
    logic signed [CORD_W-1:0]   r_x, r_y;
    logic signed [Z_W-1:0]      r_z;
    logic                       r_origin;
    logic [MAG_W-1:0]           r_mag;
    logic signed [PH_W-1:0]     r_ph;

    logic signed [MUL_A_W-1:0]  w_a;
    logic signed [MUL_B_W-1:0]  w_b;
    logic signed [MUL_PP_W-1:0] w_pp;
    logic signed [MUL_P_W-1:0]  w_r16, w_r24, w_q0;
    logic signed [STATE_W-1:0]  w_q0_sat;
    logic                       w_rng;
    logic [5:0]                 w_sqsh;
    logic [SQ_W-1:0]            w_bit, w_trial, w_rnd;
    logic signed [CORD_W-1:0]   w_sx, w_sy;
    logic signed [Z_W-1:0]      w_at;
    logic signed [Z_W-12:0]     w_zr;
    logic [MAG_W-1:0]           w_mag;
    logic signed [PH_W-1:0]     w_ph;

    // operand select for the shared multiplier
    always_comb begin
        case (i_cmd.op)
            OP_RS: begin
                w_a = r_re;
                w_b = MUL_B_W'(signed'({1'b0, i_scale}));
            end
            OP_IS: begin
                w_a = r_im;
                w_b = MUL_B_W'(signed'({1'b0, i_scale}));
            end
            OP_RS2: begin
                w_a = MUL_A_W'(signed'(r_rs[COEF_W-1:0]));
                w_b = MUL_B_W'(signed'(r_rs[COEF_W-1:0]));
            end
            OP_IS2: begin
                w_a = MUL_A_W'(signed'(r_is[COEF_W-1:0]));
                w_b = MUL_B_W'(signed'(r_is[COEF_W-1:0]));
            end
            OP_RE: begin
                w_a = MUL_A_W'(r_q1);
                w_b = MUL_B_W'(i_cos);
            end
            OP_IM: begin
                w_a = MUL_A_W'(r_q1);
                w_b = MUL_B_W'(i_sin);
            end
            default: begin
                w_a = MUL_A_W'(r_q1);
                w_b = MUL_B_W'(i_cos) <<< 1;
            end
        endcase
    end

    // one 26x27 partial product per cycle
    always_comb begin
        if (i_cmd.mul_hi) begin
            w_pp = MUL_PP_W'(signed'(w_a[MUL_A_W-1:MUL_H_W])) * MUL_PP_W'(w_b);
        end else begin
            w_pp = MUL_PP_W'(signed'({1'b0, w_a[MUL_H_W-1:0]})) * MUL_PP_W'(w_b);
        end
    end

    // rounding and recurrence update
    always_comb begin
        w_r16 = (r_acc + HALF16) >>> 16;
        w_r24 = (r_acc + HALF24) >>> 24;
        w_q0  = w_r16 - MUL_P_W'(r_q2) + MUL_P_W'(r_smp);
        if (w_q0 > ST_HI) begin
            w_q0_sat = STATE_W'(ST_HI);
        end else if (w_q0 < ST_LO) begin
            w_q0_sat = STATE_W'(ST_LO);
        end else begin
            w_q0_sat = STATE_W'(w_q0);
        end
    end

    // square root step and final magnitude
    always_comb begin
        w_rng   = (r_rs > RS_HI) || (r_rs < RS_LO) || (r_is > RS_HI) || (r_is < RS_LO);
        w_sqsh  = 6'(2*(SQRT_STEPS-1)) - {i_cmd.idx, 1'b0};
        w_bit   = SQ_W'(1) << w_sqsh;
        w_trial = r_root + w_bit;
        w_rnd   = (r_sq > r_root) ? r_root + SQ_W'(1) : r_root;
        if (w_rng || (w_rnd > SQ_W'(MAG_MAX))) begin
            w_mag = MAG_W'(MAG_MAX);
        end else begin
            w_mag = w_rnd[MAG_W-1:0];
        end
    end

    // CORDIC step terms and phase rounding
    always_comb begin
        w_sx = r_x >>> i_cmd.idx;
        w_sy = r_y >>> i_cmd.idx;
        w_at = atan_q24(i_cmd.idx);
        w_zr = (Z_W-11)'((r_z + ZRND) >>> 11);
        if (r_origin) begin
            w_ph = '0;
        end else if (w_zr > PLIM) begin
            w_ph = PH_W'(PLIM);
        end else if (w_zr < -PLIM) begin
            w_ph = PH_W'(-PLIM);
        end else begin
            w_ph = PH_W'(w_zr);
        end
    end

    assign o_sts.norm_fit = (&r_re[MUL_A_W-1:NORM_BIT] || ~|r_re[MUL_A_W-1:NORM_BIT]) &&
                            (&r_im[MUL_A_W-1:NORM_BIT] || ~|r_im[MUL_A_W-1:NORM_BIT]);
    assign o_sts.origin   = r_origin;

    // recurrence state, cleared at reset and after each block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1 <= '0;
            r_q2 <= '0;
        end else if (i_cmd.apply && (i_cmd.op == OP_REC)) begin
            r_q2 <= r_q1;
            r_q1 <= w_q0_sat;
        end else if (i_cmd.apply && (i_cmd.op == OP_IM)) begin
            r_q1 <= '0;
            r_q2 <= '0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_smp) begin
            r_smp <= i_sample;
        end
        if (i_cmd.mul_lo || i_cmd.mul_hi) begin
            r_prod <= w_pp;
        end
        if (i_cmd.mul_hi) begin
            r_acc <= MUL_P_W'(r_prod);
        end else if (i_cmd.mul_add) begin
            r_acc <= r_acc + (MUL_P_W'(r_prod) <<< MUL_H_W);
        end
        if (i_cmd.apply) begin
            case (i_cmd.op)
                OP_RE:   r_re <= MUL_A_W'(w_r16 - MUL_P_W'(r_q2));
                OP_IM:   r_im <= MUL_A_W'(w_r16);
                OP_RS:   r_rs <= RS_W'(w_r24);
                OP_IS:   r_is <= RS_W'(w_r24);
                OP_RS2:  r_sq <= SQ_W'(r_acc);
                OP_IS2: begin
                    r_sq   <= r_sq + SQ_W'(r_acc);
                    r_root <= '0;
                end
                default: ;
            endcase
        end
        // one root bit per cycle
        if (i_cmd.sqrt_step) begin
            if (r_sq >= w_trial) begin
                r_sq   <= r_sq - w_trial;
                r_root <= (r_root >> 1) + w_bit;
            end else begin
                r_root <= r_root >> 1;
            end
        end
        // halve both operands until they fit 31 bits
        if (i_cmd.norm_shift) begin
            r_re <= r_re >>> 1;
            r_im <= r_im >>> 1;
        end
        // quadrant fold then rotations
        if (i_cmd.cord_init) begin
            r_origin <= (r_re == '0) && (r_im == '0);
            if (r_im < 0) begin
                r_x <= -CORD_W'(r_im);
                r_y <= -CORD_W'(r_re);
                r_z <= (r_re >= 0) ? PI_Z : -PI_Z;
            end else begin
                r_x <= CORD_W'(r_im);
                r_y <= CORD_W'(r_re);
                r_z <= '0;
            end
        end else if (i_cmd.cord_step) begin
            if (r_y > 0) begin
                r_x <= r_x + w_sy;
                r_y <= r_y - w_sx;
                r_z <= r_z + w_at;
            end else begin
                r_x <= r_x - w_sy;
                r_y <= r_y + w_sx;
                r_z <= r_z - w_at;
            end
        end
        if (i_cmd.out_load) begin
            r_mag <= w_mag;
            r_ph  <= w_ph;
        end
    end

    assign o_magnitude = r_mag;
    assign o_phase     = r_ph;

endmodule

`default_nettype wire

[rtl/gtd_ctrl.sv]
// Controller: sample count, operation sequencing, handshakes and result valid.
// Depends on gtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gtd_ctrl import gtd_pkg::*; #(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire [BLEN_W-1:0]  i_block_length,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  t_dp_sts           i_sts,
    output t_dp_cmd           o_cmd
);

    localparam int CW = $clog2(MAX_BLOCK + 1);
    localparam int LW = (CW > BLEN_W) ? CW : BLEN_W;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MLO   = 9'b000000010,
        ST_MHI   = 9'b000000100,
        ST_MADD  = 9'b000001000,
        ST_APPLY = 9'b000010000,
        ST_SQRT  = 9'b000100000,
        ST_NORM  = 9'b001000000,
        ST_CORD  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } t_state;

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [IDX_W-1:0] r_step, n_step;
    logic             r_out_valid, n_out_valid;
    logic [LW-1:0]    w_len, w_next;
    logic             w_end;

    // effective block length, clamped to 1..MAX_BLOCK
    always_comb begin
        if (i_block_length == '0) begin
            w_len = LW'(1);
        end else if (LW'(i_block_length) > LW'(MAX_BLOCK)) begin
            w_len = LW'(MAX_BLOCK);
        end else begin
            w_len = LW'(i_block_length);
        end
        w_next = LW'(r_cnt) + LW'(1);
        w_end  = (w_next >= w_len);
    end

    // sequencing
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_cnt       = r_cnt;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.op    = r_op;
        o_cmd.idx   = r_step;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_smp = 1'b1;
                    n_op           = OP_REC;
                    n_state        = ST_MLO;
                end
            end
            ST_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_MHI;
            end
            ST_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ST_MADD;
            end
            ST_MADD: begin
                o_cmd.mul_add = 1'b1;
                n_state       = ST_APPLY;
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = ST_MLO;
                case (r_op)
                    OP_REC: begin
                        if (w_end) begin
                            n_cnt = '0;
                            n_op  = OP_RE;
                        end else begin
                            n_cnt   = CW'(w_next);
                            n_state = ST_IDLE;
                        end
                    end
                    OP_RE:  n_op = OP_IM;
                    OP_IM:  n_op = OP_RS;
                    OP_RS:  n_op = OP_IS;
                    OP_IS:  n_op = OP_RS2;
                    OP_RS2: n_op = OP_IS2;
                    default: begin
                        n_step  = '0;
                        n_state = ST_SQRT;
                    end
                endcase
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_step == IDX_W'(SQRT_STEPS-1)) begin
                    n_state = ST_NORM;
                end else begin
                    n_step = r_step + IDX_W'(1);
                end
            end
            ST_NORM: begin
                if (i_sts.norm_fit) begin
                    o_cmd.cord_init = 1'b1;
                    n_step          = '0;
                    n_state         = ST_CORD;
                end else begin
                    o_cmd.norm_shift = 1'b1;
                end
            end
            ST_CORD: begin
                o_cmd.cord_step = 1'b1;
                if (r_step == IDX_W'(CORD_STEPS-1)) begin
                    n_state = ST_OUT;
                end else begin
                    n_step = r_step + IDX_W'(1);
                end
            end
            ST_OUT: begin
                // load only when the result register is free this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_REC;
            r_cnt       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_cnt       <= n_cnt;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/gtd_chk.sv]
// Port-level checker for the Goertzel tone detector, bound to the top level.
// Depends on gtd_pkg and goertzel_tone_detector_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "goertzel_tone_detector_assert.svh"

module gtd_chk import gtd_pkg::*; (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     i_in_valid,
    input wire                     i_in_ready,
    input wire                     i_out_valid,
    input wire                     i_out_ready,
    input wire [MAG_W-1:0]         i_magnitude,
    input wire signed [PH_W-1:0]   i_phase
);

    // a sample beat keeps the input closed while it goes through the multiplier
    `GTD_ASSERT_NEXT(a_one_at_a_time, i_in_valid && i_in_ready, !i_in_ready, "sample taken too soon")
    // phase stays within +-pi
    `GTD_ASSERT_NOW(a_phase_range, i_out_valid, (i_phase <= PH_W'(PHASE_LIM)) && (i_phase >= -PH_W'(PHASE_LIM)), "phase out of range")
    // a stalled result beat stays
    `GTD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped")
    // and keeps its payload
    `GTD_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_magnitude) && $stable(i_phase), "result changed")

endmodule

bind goertzel_tone_detector gtd_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_magnitude (o_res.magnitude),
    .i_phase     (o_res.phase)
);

`default_nettype wire

[verif/tb_goertzel_tone_detector.sv]
// Testbench of the Goertzel tone detector: drives samples and register writes,
// predicts each block result and checks magnitude and phase beat by beat.
// Depends on gtd_pkg, gtd_if and goertzel_tone_detector.
`timescale 1ns / 1ps

module tb_goertzel_tone_detector;
    import gtd_pkg::*;

    localparam longint CYCLE_LIMIT = 1000000;
    localparam longint I64_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
    localparam longint ST_MAX  = (64'sd1 <<< 47) - 1;
    localparam longint ST_MIN  = -(64'sd1 <<< 47);

    typedef struct packed {
        logic [MAG_W-1:0]       magnitude;
        logic signed [PH_W-1:0] phase;
    } t_tone;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gtd_sample_if smp_if();
    gtd_result_if res_if();
    gtd_cfg_if    cfg_if();

    goertzel_tone_detector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #1 i_clk = ~i_clk;

    // predictor state and register copies
    logic [BLEN_W-1:0]         blk_len;
    logic signed [COEF_W-1:0]  cos_q16;
    logic signed [COEF_W-1:0]  sin_q16;
    logic [SCALE_W-1:0]        scale_q24;
    int unsigned               smp_cnt;
    longint                    q1, q2;

    t_tone  tone_q[$];
    int     err_cnt = 0;
    int     tone_cnt = 0;
    int     smp_total = 0;
    longint cycles = 0;
    int     burst_left = 0;

    longint atan_tab[9] = '{13176795, 7778716, 4110061, 2086331, 1047214,
                            524117, 262123, 131069, 65536};

    function automatic longint clamp64(logic signed [127:0] v);
        if (v > I64_MAX) return I64_MAX;
        if (v < I64_MIN) return I64_MIN;
        return v[63:0];
    endfunction

    function automatic longint negsat(longint v);
        return (v == I64_MIN) ? I64_MAX : -v;
    endfunction

    // round(x*c/2^sh) with 64-bit saturation
    function automatic longint mul_round(longint x, longint c, int sh);
        longint hi, lo, f;
        logic signed [127:0] p;
        hi = x >>> sh;
        lo = x & ((64'sd1 <<< sh) - 1);
        p = hi;
        p = p * c;
        f = (lo * c + (64'sd1 <<< (sh - 1))) >>> sh;
        p = clamp64(p);
        return clamp64(p + f);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // vectoring CORDIC for atan2(y, x)
    function automatic longint cordic_phase(longint y, longint x);
        longint z, nx, ny, a, big;
        z = 0;
        big = 64'sd1 <<< 30;
        if (x == 0 && y == 0) return 0;
        while (y >= big || y < -big || x >= big || x < -big) begin
            y = y >>> 1;
            x = x >>> 1;
        end
        if (x < 0) begin
            z = (y >= 0) ? PI_Q24 : -PI_Q24;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORD_STEPS; i++) begin
            a = (i < 9) ? atan_tab[i] : (64'sd1 <<< (24 - i));
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += a;
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= a;
            end
            x = nx;
            y = ny;
        end
        z = (z + 1024) >>> 11;
        if (z > PHASE_LIM) z = PHASE_LIM;
        if (z < -PHASE_LIM) z = -PHASE_LIM;
        return z;
    endfunction

    // advance the recurrence by one sample; queue a tone when the block ends
    function automatic void goertzel_advance(logic signed [SAMPLE_W-1:0] s);
        longint len, q0, re, im, rs, is_, ph;
        longint unsigned sq, r, mag;
        t_tone t;
        len = blk_len;
        if (len < 1) len = 1;
        if (len > MAX_BLOCK_DEF) len = MAX_BLOCK_DEF;
        q0 = mul_round(q1, 2 * longint'(cos_q16), 16);
        q0 = clamp64(128'(q0) + negsat(q2));
        q0 = clamp64(128'(q0) + s);
        if (q0 > ST_MAX) q0 = ST_MAX;
        if (q0 < ST_MIN) q0 = ST_MIN;
        q2 = q1;
        q1 = q0;
        smp_cnt++;
        if (smp_cnt < len) return;
        re  = clamp64(128'(mul_round(q1, cos_q16, 16)) + negsat(q2));
        im  = mul_round(q1, sin_q16, 16);
        rs  = mul_round(re, longint'(scale_q24), 24);
        is_ = mul_round(im, longint'(scale_q24), 24);
        if (rs > MAG_MAX || rs < -MAG_MAX || is_ > MAG_MAX || is_ < -MAG_MAX) begin
            mag = MAG_MAX;
        end else begin
            sq = rs * rs + is_ * is_;
            r = int_sqrt(sq);
            if (sq - r * r > r) r++;
            mag = (r > MAG_MAX) ? MAG_MAX : r;
        end
        ph = cordic_phase(re, im);
        t.magnitude = mag[MAG_W-1:0];
        t.phase = ph[PH_W-1:0];
        tone_q.push_back(t);
        smp_cnt = 0;
        q1 = 0;
        q2 = 0;
    endfunction

    // wait for outstanding tones, then let the back end settle
    task automatic wait_idle();
        while (tone_q.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    // one register write beat; called at a falling edge
    task automatic reg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_BLEN:  blk_len   = val[BLEN_W-1:0];
            CFG_COS:   cos_q16   = val[COEF_W-1:0];
            CFG_SIN:   sin_q16   = val[COEF_W-1:0];
            CFG_SCALE: scale_q24 = val[SCALE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_tone(int len, int c, int s, int sc);
        wait_idle();
        reg_write(CFG_BLEN, CFG_DATA_W'(len));
        reg_write(CFG_COS, CFG_DATA_W'(c));
        reg_write(CFG_SIN, CFG_DATA_W'(s));
        reg_write(CFG_SCALE, CFG_DATA_W'(sc));
    endtask

    // one sample beat, sent in bursts with random gaps; called at a falling edge
    task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                smp_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        smp_if.valid  <= 1'b1;
        smp_if.sample <= s;
        do @(posedge i_clk); while (!smp_if.ready);
        goertzel_advance(s);
        smp_total++;
        @(negedge i_clk);
    endtask

    task automatic stop_samples();
        smp_if.valid <= 1'b0;
        burst_left = 0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return SAMPLE_W'($urandom_range(0, 7)) - 16'sd4;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // extremes of sample and coefficients with one-sample blocks
    task automatic test_extremes();
        logic signed [SAMPLE_W-1:0] pts[6] = '{16'sh8000, 16'sh7fff, 16'sd0,
                                             -16'sd1, 16'sd1, 16'sh5555};
        set_tone(1, 65536, 0, 131072);
        foreach (pts[i]) send_sample(pts[i]);
        stop_samples();
        set_tone(1, -65536, 65536, 33554432);
        foreach (pts[i]) send_sample(pts[i]);
        stop_samples();
        set_tone(1, 46341, -46341, 0);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        stop_samples();
    endtask

    // zero length behaves as one; origin gives zero phase
    task automatic test_zero_length();
        set_tone(0, 23170, 62813, 16777216);
        send_sample(16'sd0);
        send_sample(-16'sd1234);
        send_sample(16'sd3);
        stop_samples();
    endtask

    // length lowered with a partial block in flight
    task automatic test_length_lowered();
        set_tone(10, 32768, 56756, 3355443);
        repeat (5) send_sample(rand_sample());
        stop_samples();
        wait_idle();
        reg_write(CFG_BLEN, CFG_DATA_W'(3));
        send_sample(16'sd1000);
        stop_samples();
    endtask

    // long block of full-scale DC with a large coefficient saturates the state
    task automatic test_long_block();
        set_tone(512, 131071, 0, 33554432);
        repeat (512) send_sample(16'sh7fff);
        stop_samples();
    endtask

    // random settings, mostly short blocks
    task automatic test_random(int n);
        int len, c, s, sc, left;
        left = n;
        while (left > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            c   = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 131072) - 65536;
            s   = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 131072) - 65536;
            sc  = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1 << 20);
            set_tone(len, c, s, sc);
            for (int k = 0; k < 3 * len && left > 0; k++) begin
                send_sample(rand_sample());
                left--;
            end
            stop_samples();
        end
    endtask

    // result receiver: free-running stretches, random stalls and long holds
    int  rdy_left = 0;
    int  rdy_mode = 0;
    always @(negedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 2);
            rdy_left = $urandom_range(10, 150);
        end
        rdy_left--;
        case (rdy_mode)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= ($urandom_range(0, 2) != 0);
            default: res_if.ready <= (rdy_left % 40 == 0);
        endcase
    end

    // result checker
    always @(posedge i_clk) begin
        t_tone exp_t;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (tone_q.size() == 0) begin
                $display("%0t: unexpected tone mag=%0d phase=%0d", $time,
                         res_if.magnitude, res_if.phase);
                err_cnt++;
            end else begin
                exp_t = tone_q.pop_front();
                tone_cnt++;
                if (res_if.magnitude !== exp_t.magnitude) begin
                    $display("%0t: magnitude expected %0d actual %0d", $time,
                             exp_t.magnitude, res_if.magnitude);
                    err_cnt++;
                end
                if (res_if.phase !== exp_t.phase) begin
                    $display("%0t: phase expected %0d actual %0d", $time,
                             exp_t.phase, res_if.phase);
                    err_cnt++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        smp_if.valid  = 1'b0;
        smp_if.sample = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = CFG_BLEN;
        cfg_if.data   = '0;
        res_if.ready  = 1'b0;
        blk_len   = 256;
        cos_q16   = 65536;
        sin_q16   = 0;
        scale_q24 = 131072;
        smp_cnt   = 0;
        q1 = 0;
        q2 = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_extremes();
        test_zero_length();
        test_length_lowered();
        test_long_block();
        test_random(700);

        while (tone_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("Covered %0d samples and %0d tones over extreme and random settings,",
                 smp_total, tone_cnt);
        $display("including clamped block lengths and saturated state; %0d mismatches.",
                 err_cnt);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
